[design/wdh_pkg.sv]
// ----------------------------------------------------------------------------
// wdh_pkg
// Types, register indexes and helpers shared by the wheel report block.
// ----------------------------------------------------------------------------
package wdh_pkg;

  localparam int DELTA_W = 16;
  localparam int STEP_W  = 15;
  localparam int Y_W     = 4;

  typedef enum logic [1:0] {
    REG_WHEEL_MODE  = 2'd0,
    REG_VOLUME_STEP = 2'd1,
    REG_ZOOM_STEP   = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    MODE_SCROLL = 3'd0,
    MODE_PAN    = 3'd1,
    MODE_ZOOM   = 3'd2,
    MODE_VOLUME = 3'd3,
    MODE_SELECT = 3'd4
  } wheel_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_ACCUM,
    ST_CLICK,
    ST_FINISH
  } state_t;

  localparam logic signed [Y_W-1:0] Y_UP   = 4'sd5;
  localparam logic signed [Y_W-1:0] Y_DOWN = -4'sd5;

  // negation clipped to the 16-bit range
  function automatic logic signed [DELTA_W-1:0] neg_sat(input logic signed [DELTA_W-1:0] v);
    logic signed [DELTA_W-1:0] r;
    if (v == {1'b1, {(DELTA_W-1){1'b0}}}) begin
      r = {1'b0, {(DELTA_W-1){1'b1}}};
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

[design/wdh_div.sv]
// ----------------------------------------------------------------------------
// wdh_div
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module wdh_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wdh_pkg::DELTA_W-1:0]   dividend,
  input  logic [wdh_pkg::STEP_W-1:0]    divisor,
  output logic                          done,
  output logic [wdh_pkg::DELTA_W-1:0]   quotient
);
  import wdh_pkg::*;

  localparam int CNT_W = $clog2(DELTA_W);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [STEP_W-1:0]    rem;
  logic [STEP_W-1:0]    dvs;
  logic [DELTA_W-1:0]   quo;
  logic [STEP_W:0]      rem_sh;
  logic [STEP_W:0]      trial;
  logic                 fits;

  assign rem_sh   = {rem, quo[DELTA_W-1]};
  assign trial    = rem_sh - {1'b0, dvs};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DELTA_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? trial[STEP_W-1:0] : rem_sh[STEP_W-1:0];
      quo <= {quo[DELTA_W-2:0], fits};
    end
  end

endmodule

[design/wheel_delta_to_hid_report.sv]
// ----------------------------------------------------------------------------
// wheel_delta_to_hid_report
// Wheel delta to mouse report / volume click converter, one word at a time.
// ----------------------------------------------------------------------------
// Each input word gives exactly one output word. Ticks, scroll, pan, select
// and unused modes go to the finish state; a zero delta passes the click
// state; volume mode passes accumulate and click (saturating add, then the
// click compare); zoom waits on the 16-step serial divider. The input is
// not ready while a word is in work; the next word may be accepted while
// the previous result still waits in the output register. Registers are
// written with wr_en and may only be changed while the block is idle.
module wheel_delta_to_hid_report #(
  parameter int ACC_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 kind,
  input  logic signed [wdh_pkg::DELTA_W-1:0]   delta,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 report_valid,
  output logic                                 left_button,
  output logic signed [wdh_pkg::Y_W-1:0]       y_move,
  output logic signed [wdh_pkg::DELTA_W-1:0]   vertical_wheel,
  output logic signed [wdh_pkg::DELTA_W-1:0]   horizontal_pan,
  output logic                                 click_valid,
  output logic                                 click_up,
  input  logic                                 wr_en,
  input  logic [1:0]                           wr_index,
  input  logic [wdh_pkg::STEP_W-1:0]           wr_data
);
  import wdh_pkg::*;

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  state_t                      state, state_next;
  wheel_mode_t                 wheel_mode;
  logic [STEP_W-1:0]           volume_step;
  logic [STEP_W-1:0]           zoom_step;
  logic signed [ACC_WIDTH-1:0] acc;
  logic                        click_hold;
  logic                        select_phase;

  logic signed [DELTA_W-1:0]   delta_r;
  logic                        res_report;
  logic                        res_left;
  logic signed [Y_W-1:0]       res_y;
  logic signed [DELTA_W-1:0]   res_vw;
  logic signed [DELTA_W-1:0]   res_hp;
  logic                        res_click;
  logic                        res_up;

  logic                        accept;
  logic                        load_out;
  logic                        div_start;
  logic                        div_done;
  logic [DELTA_W-1:0]          div_quo;
  logic [DELTA_W-1:0]          delta_mag;
  logic [STEP_W-1:0]           vstep;
  logic [STEP_W-1:0]           zstep;
  logic signed [DELTA_W-1:0]   zoom_vw;

  logic signed [ACC_WIDTH:0]   acc_ext;
  logic signed [ACC_WIDTH:0]   step_ext;
  logic signed [ACC_WIDTH:0]   acc_sum;
  logic signed [ACC_WIDTH-1:0] acc_sat;
  logic signed [ACC_WIDTH:0]   acc_dn;
  logic signed [ACC_WIDTH:0]   acc_up;
  logic                        click_dn_ok;
  logic                        click_up_ok;

  assign accept    = in_valid && in_ready;
  assign vstep     = (volume_step == '0) ? STEP_W'(1) : volume_step;
  assign zstep     = (zoom_step == '0) ? STEP_W'(1) : zoom_step;
  assign delta_mag = delta[DELTA_W-1] ? DELTA_W'(-delta) : DELTA_W'(delta);

  // quotient magnitude back to the negated, clipped wheel value
  assign zoom_vw = delta_r[DELTA_W-1]
                   ? (div_quo[DELTA_W-1] ? {1'b0, {(DELTA_W-1){1'b1}}} : $signed(div_quo))
                   : -$signed(div_quo);

  // saturating accumulate
  assign acc_ext  = {acc[ACC_WIDTH-1], acc};
  assign acc_sum  = acc_ext + {{(ACC_WIDTH+1-DELTA_W){delta_r[DELTA_W-1]}}, delta_r};
  assign acc_sat  = (acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1])
                    ? (acc_sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX)
                    : acc_sum[ACC_WIDTH-1:0];

  // click thresholds
  assign step_ext    = {{(ACC_WIDTH+1-STEP_W){1'b0}}, vstep};
  assign acc_dn      = acc_ext - step_ext;
  assign acc_up      = acc_ext + step_ext;
  assign click_dn_ok = !acc_dn[ACC_WIDTH];
  assign click_up_ok = acc_up[ACC_WIDTH] || (acc_up == '0);

  wdh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (delta_mag),
    .divisor  (zstep),
    .done     (div_done),
    .quotient (div_quo)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (kind) begin
            state_next = ST_FINISH;
          end else if (delta == '0) begin
            state_next = ST_CLICK;
          end else begin
            case (wheel_mode)
              MODE_ZOOM:   state_next = ST_DIVIDE;
              MODE_VOLUME: state_next = ST_ACCUM;
              default:     state_next = ST_FINISH;
            endcase
          end
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_ACCUM:  state_next = ST_CLICK;
      ST_CLICK:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // handshake and unit control
  always_comb begin
    in_ready  = (state == ST_IDLE);
    load_out  = (state == ST_FINISH) && (!out_valid || out_ready);
    div_start = accept && !kind && (delta != '0) && (wheel_mode == MODE_ZOOM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      wheel_mode   <= MODE_SCROLL;
      volume_step  <= STEP_W'(4);
      zoom_step    <= STEP_W'(4);
      acc          <= '0;
      click_hold   <= 1'b0;
      select_phase <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        case (wr_index)
          REG_WHEEL_MODE:  wheel_mode  <= wheel_mode_t'(wr_data[2:0]);
          REG_VOLUME_STEP: volume_step <= wr_data;
          REG_ZOOM_STEP:   zoom_step   <= wr_data;
          default: ;
        endcase
      end
      if (accept && kind) begin
        click_hold <= 1'b0;
      end
      if (accept && !kind && (delta != '0) && (wheel_mode == MODE_SELECT)) begin
        select_phase <= !select_phase;
      end
      if (state == ST_ACCUM) begin
        acc <= acc_sat;
      end
      if ((state == ST_CLICK) && !click_hold) begin
        if (click_dn_ok) begin
          acc        <= acc_dn[ACC_WIDTH-1:0];
          click_hold <= 1'b1;
        end else if (click_up_ok) begin
          acc        <= acc_up[ACC_WIDTH-1:0];
          click_hold <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result word under construction
  always_ff @(posedge clk) begin
    if (accept) begin
      delta_r    <= delta;
      res_report <= 1'b0;
      res_left   <= 1'b0;
      res_y      <= '0;
      res_vw     <= '0;
      res_hp     <= '0;
      res_click  <= 1'b0;
      res_up     <= 1'b0;
      if (!kind && (delta != '0)) begin
        case (wheel_mode)
          MODE_SCROLL: begin
            res_report <= 1'b1;
            res_vw     <= neg_sat(delta);
          end
          MODE_PAN: begin
            res_report <= 1'b1;
            res_hp     <= delta;
          end
          MODE_SELECT: begin
            res_report <= 1'b1;
            res_left   <= 1'b1;
            res_y      <= select_phase ? Y_UP : Y_DOWN;
            res_vw     <= neg_sat(delta);
          end
          default: ;
        endcase
      end
    end
    if ((state == ST_DIVIDE) && div_done && (div_quo != '0)) begin
      res_report <= 1'b1;
      res_vw     <= zoom_vw;
    end
    if ((state == ST_CLICK) && !click_hold) begin
      if (click_dn_ok) begin
        res_click <= 1'b1;
        res_up    <= 1'b0;
      end else if (click_up_ok) begin
        res_click <= 1'b1;
        res_up    <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      report_valid   <= res_report;
      left_button    <= res_left;
      y_move         <= res_y;
      vertical_wheel <= res_vw;
      horizontal_pan <= res_hp;
      click_valid    <= res_click;
      click_up       <= res_up;
    end
  end

`ifndef SYNTH
  // a word never carries both a report and a click
  a_report_or_click : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(report_valid && click_valid))
    else $error("report and click in one word");

  // one word in work at a time
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready straight after acceptance");

  // pointer movement only comes with the select button
  a_y_needs_left : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (y_move != '0)) |-> (left_button && report_valid))
    else $error("y movement without left button");

  // a pending result is never overwritten before it is taken
  a_hold_result : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(vertical_wheel) && $stable(click_valid)))
    else $error("pending result changed");
`endif

endmodule
